// ===== rtl/core/call_arc_profiler_table_assert.svh =====
`ifndef CALL_ARC_PROFILER_TABLE_ASSERT_SVH
`define CALL_ARC_PROFILER_TABLE_ASSERT_SVH
// same-cycle implication, clocked on clk_i, off while in reset
`define CAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define CAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`endif

// ===== rtl/core/cap_pkg.sv =====
package cap_pkg;

  localparam int HashBitsDef    = 16;
  localparam int CallerDepthDef = 4096;
  localparam int ArcDepthDef    = 4096;
  localparam int HashW          = 16;
  localparam int LimitW         = 13;
  localparam int CfgIdxW        = 2;

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_CFULL  = 2'd1;
  localparam logic [1:0] ST_AFULL  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIMIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALIMIT  = 2'd2;

  localparam logic [LimitW-1:0] LIMIT_RST = 13'd4096;

  typedef struct packed {
    logic [31:0]      caller_pc;
    logic [31:0]      callee_pc;
    logic [31:0]      elapsed_cycles;
    logic [11:0]      parent_arc_index;
    logic             paused;
    logic [HashW-1:0] hash;
  } item_t;

endpackage

// ===== rtl/core/call_arc_profiler_table.sv =====
// Path: front register, then FIFO, then back end. A paused event is answered
// from the idle state; a recorded one reads its hash head, walks the caller
// chain and arc list, moves found nodes to the front and counts or adds the
// arc; a full table ends it sooner. Throughput: one event at a time; busy
// drops in the strobe cycle. Reset: a clearing pass zeroes every hash head;
// busy is high meanwhile. Results are never stalled by the receiver.
module call_arc_profiler_table import cap_pkg::*; #(
  parameter int HASH_BITS    = HashBitsDef,
  parameter int CALLER_DEPTH = CallerDepthDef,
  parameter int ARC_DEPTH    = ArcDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LimitW-1:0]  cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        caller_pc_i,
  input  logic [31:0]        callee_pc_i,
  input  logic [31:0]        elapsed_cycles_i,
  input  logic [11:0]        parent_arc_index_i,
  input  logic               thread_enable_i,
  output logic               result_strobe_o,
  output logic               recorded_o,
  output logic [11:0]        arc_index_o,
  output logic [31:0]        arc_count_o,
  output logic [1:0]         table_status_o,
  output logic [31:0]        event_total_o
);

  logic              en_q;
  logic [LimitW-1:0] climit_q, alimit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      climit_q <= LIMIT_RST;
      alimit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: en_q     <= cfg_wdata_i[0];
        CFG_CLIMIT: climit_q <= cfg_wdata_i;
        CFG_ALIMIT: alimit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic  push, pop, q_valid, q_full, front_valid, back_busy;
  item_t f_item, q_item;
  logic [1:0] status;

  assign busy = front_valid || q_valid || back_busy;

  cap_front u_front (
    .clk_i, .rst_ni,
    .accept_i           (start && !busy),
    .caller_pc_i, .callee_pc_i, .elapsed_cycles_i, .parent_arc_index_i, .thread_enable_i,
    .enable_i           (en_q),
    .status_i           (status),
    .full_i             (q_full),
    .push_o             (push),
    .item_o             (f_item),
    .valid_o            (front_valid)
  );

  cap_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  cap_back #(
    .HASH_BITS    (HASH_BITS),
    .CALLER_DEPTH (CALLER_DEPTH),
    .ARC_DEPTH    (ARC_DEPTH)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .caller_limit_i  (climit_q),
    .arc_limit_i     (alimit_q),
    .busy_o          (back_busy),
    .status_o        (status),
    .result_strobe_o, .recorded_o, .arc_index_o, .arc_count_o,
    .table_status_o, .event_total_o
  );

endmodule

// ===== rtl/core/cap_front.sv =====
module cap_front import cap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [31:0] caller_pc_i,
  input  logic [31:0] callee_pc_i,
  input  logic [31:0] elapsed_cycles_i,
  input  logic [11:0] parent_arc_index_i,
  input  logic        thread_enable_i,
  input  logic        enable_i,
  input  logic [1:0]  status_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o,
  output logic        valid_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  assign push_o  = valid_q && !full_i;
  assign item_o  = item_q;
  assign valid_o = valid_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) valid_d = 1'b0;
    if (accept_i) begin
      valid_d                 = 1'b1;
      item_d.caller_pc        = caller_pc_i;
      item_d.callee_pc        = callee_pc_i;
      item_d.elapsed_cycles   = elapsed_cycles_i;
      item_d.parent_arc_index = parent_arc_index_i;
      item_d.paused           = !enable_i || !thread_enable_i || (status_i != ST_RUN);
      item_d.hash             = caller_pc_i[31:16] ^ caller_pc_i[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== rtl/core/cap_fifo.sv =====
module cap_fifo import cap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  valid_o,
  output logic  full_o
);

  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign item_o  = slot_q[rd_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

endmodule

// ===== rtl/core/cap_back.sv =====
module cap_back import cap_pkg::*; #(
  parameter int HASH_BITS    = HashBitsDef,
  parameter int CALLER_DEPTH = CallerDepthDef,
  parameter int ARC_DEPTH    = ArcDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              pop_o,
  input  logic [LimitW-1:0] caller_limit_i,
  input  logic [LimitW-1:0] arc_limit_i,
  output logic              busy_o,
  output logic [1:0]        status_o,
  output logic              result_strobe_o,
  output logic              recorded_o,
  output logic [11:0]       arc_index_o,
  output logic [31:0]       arc_count_o,
  output logic [1:0]        table_status_o,
  output logic [31:0]       event_total_o
);

  localparam int CIW = $clog2(CALLER_DEPTH);
  localparam int AIW = $clog2(ARC_DEPTH);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_CCMP  = 4'd3;
  localparam logic [3:0] S_CMTF  = 4'd4;
  localparam logic [3:0] S_CNEW  = 4'd5;
  localparam logic [3:0] S_ARC   = 4'd6;
  localparam logic [3:0] S_ACMP  = 4'd7;
  localparam logic [3:0] S_AMTF  = 4'd8;
  localparam logic [3:0] S_AINC  = 4'd9;
  localparam logic [3:0] S_ANEW  = 4'd10;

  logic [3:0]  state_q, state_d;
  item_t       item_q, item_d;
  logic [HASH_BITS-1:0] clr_q, clr_d;
  logic [CIW-1:0] c_q, c_d, prev_q, prev_d, chead_q, chead_d;
  logic [AIW-1:0] ahead_q, ahead_d, acur_q, acur_d, aprev_q, aprev_d;
  logic [CIW:0] cused_q, cused_d, cu_inc;
  logic [AIW:0] aused_q, aused_d, au_inc;
  logic [1:0]  status_q, status_d;
  logic [31:0] evcnt_q, evcnt_d;
  logic        res_valid_q, res_valid_d, res_rec_q, res_rec_d;
  logic [11:0] res_arc_q, res_arc_d;
  logic [31:0] res_cnt_q, res_cnt_d;
  logic [1:0]  res_status_q, res_status_d;
  logic [HASH_BITS-1:0] hsh;

  // table memories
  logic [CIW-1:0] hh_mem [2**HASH_BITS];
  logic [31:0]    ca_mem [CALLER_DEPTH];
  logic [CIW-1:0] cn_mem [CALLER_DEPTH];
  logic [AIW-1:0] ch_mem [CALLER_DEPTH];
  logic [31:0]    ac_mem [ARC_DEPTH];
  logic [AIW-1:0] an_mem [ARC_DEPTH];
  logic [31:0]    cnt_mem [ARC_DEPTH];
  logic [31:0]    tm_mem [ARC_DEPTH];

  logic hh_we, ca_we, cn_we, ch_we, ac_we, an_we, cnt_we, tm_we;
  logic [HASH_BITS-1:0] hh_waddr, hh_raddr;
  logic [CIW-1:0] hh_wdata, hh_rdata_q;
  logic [CIW-1:0] c_raddr, ca_waddr, cn_waddr, ch_waddr, cn_wdata;
  logic [AIW-1:0] ch_wdata;
  logic [31:0]    ca_rdata_q;
  logic [CIW-1:0] cn_rdata_q;
  logic [AIW-1:0] ch_rdata_q;
  logic [AIW-1:0] a_raddr, ac_waddr, an_waddr, an_wdata, an_rdata_q;
  logic [31:0]    ac_rdata_q;
  logic [AIW-1:0] cnt_raddr, cnt_waddr, tm_raddr, tm_waddr;
  logic [31:0]    cnt_wdata, cnt_rdata_q, tm_wdata, tm_rdata_q;

  logic par_ok;

  assign hsh    = item_q.hash[HASH_BITS-1:0];
  assign cu_inc = cused_q + 1'b1;
  assign au_inc = aused_q + 1'b1;
  assign par_ok = (item_q.parent_arc_index != '0) &&
                  (32'(item_q.parent_arc_index) < 32'(ARC_DEPTH));

  always_comb begin
    state_d = state_q;  item_d = item_q;  clr_d = clr_q;
    c_d = c_q;  prev_d = prev_q;  chead_d = chead_q;
    ahead_d = ahead_q;  acur_d = acur_q;  aprev_d = aprev_q;
    cused_d = cused_q;  aused_d = aused_q;  status_d = status_q;  evcnt_d = evcnt_q;
    res_valid_d = 1'b0;  res_rec_d = res_rec_q;  res_arc_d = res_arc_q;
    res_cnt_d = res_cnt_q;  res_status_d = res_status_q;
    pop_o = 1'b0;
    hh_we = 1'b0;  hh_waddr = hsh;  hh_wdata = c_q;  hh_raddr = hsh;
    ca_we = 1'b0;  ca_waddr = c_q;  c_raddr = c_q;
    cn_we = 1'b0;  cn_waddr = c_q;  cn_wdata = chead_q;
    ch_we = 1'b0;  ch_waddr = c_q;  ch_wdata = acur_q;
    ac_we = 1'b0;  ac_waddr = acur_q;  a_raddr = acur_q;
    an_we = 1'b0;  an_waddr = acur_q;  an_wdata = ahead_q;
    cnt_we = 1'b0;  cnt_waddr = acur_q;  cnt_wdata = cnt_rdata_q + 32'd1;
    cnt_raddr = acur_q;
    tm_we = 1'b0;  tm_waddr = AIW'(item_q.parent_arc_index);
    tm_wdata = tm_rdata_q + item_q.elapsed_cycles;
    tm_raddr = AIW'(q_item_i.parent_arc_index);

    case (state_q)
      S_CLEAR: begin
        hh_we    = 1'b1;
        hh_waddr = clr_q;
        hh_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o  = 1'b1;
          item_d = q_item_i;
          if (q_item_i.paused) begin
            res_valid_d = 1'b1;  res_rec_d = 1'b0;  res_arc_d = '0;
            res_cnt_d = '0;  res_status_d = status_q;
          end else begin
            hh_raddr = q_item_i.hash[HASH_BITS-1:0];
            evcnt_d  = evcnt_q + 32'd1;
            state_d  = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        tm_we   = par_ok;
        chead_d = hh_rdata_q;
        prev_d  = '0;
        if (hh_rdata_q == '0) begin
          state_d = S_CNEW;
        end else begin
          c_d     = hh_rdata_q;
          c_raddr = hh_rdata_q;
          state_d = S_CCMP;
        end
      end
      S_CCMP: begin
        if (ca_rdata_q == item_q.caller_pc) begin
          ahead_d = ch_rdata_q;
          if (prev_q != '0) begin
            // unlink from the middle of the chain, then relink at the head
            cn_we    = 1'b1;  cn_waddr = prev_q;  cn_wdata = cn_rdata_q;
            hh_we    = 1'b1;  hh_wdata = c_q;
            state_d  = S_CMTF;
          end else begin
            state_d = S_ARC;
          end
        end else begin
          prev_d = c_q;
          if (cn_rdata_q == '0) begin
            state_d = S_CNEW;
          end else begin
            c_d     = cn_rdata_q;
            c_raddr = cn_rdata_q;
          end
        end
      end
      S_CMTF: begin
        cn_we   = 1'b1;
        state_d = S_ARC;
      end
      S_CNEW: begin
        cused_d = cu_inc;
        if ((32'(cu_inc) < 32'(caller_limit_i)) && (32'(cu_inc) < 32'(CALLER_DEPTH))) begin
          c_d      = cu_inc[CIW-1:0];
          ca_we    = 1'b1;  ca_waddr = cu_inc[CIW-1:0];
          ch_we    = 1'b1;  ch_waddr = cu_inc[CIW-1:0];  ch_wdata = '0;
          cn_we    = 1'b1;  cn_waddr = cu_inc[CIW-1:0];  cn_wdata = chead_q;
          hh_we    = 1'b1;  hh_wdata = cu_inc[CIW-1:0];
          ahead_d  = '0;
          state_d  = S_ANEW;
        end else begin
          status_d = ST_CFULL;
          res_valid_d = 1'b1;  res_rec_d = 1'b0;  res_arc_d = '0;
          res_cnt_d = '0;  res_status_d = ST_CFULL;
          state_d  = S_IDLE;
        end
      end
      S_ARC: begin
        aprev_d = '0;
        if (ahead_q == '0) begin
          state_d = S_ANEW;
        end else begin
          acur_d  = ahead_q;
          a_raddr = ahead_q;
          state_d = S_ACMP;
        end
      end
      S_ACMP: begin
        if (ac_rdata_q == item_q.callee_pc) begin
          if (aprev_q == '0) begin
            state_d = S_AINC;
          end else begin
            an_we    = 1'b1;  an_waddr = aprev_q;  an_wdata = an_rdata_q;
            state_d  = S_AMTF;
          end
        end else begin
          aprev_d = acur_q;
          if (an_rdata_q == '0) begin
            state_d = S_ANEW;
          end else begin
            acur_d  = an_rdata_q;
            a_raddr = an_rdata_q;
          end
        end
      end
      S_AMTF: begin
        an_we   = 1'b1;
        ch_we   = 1'b1;
        state_d = S_AINC;
      end
      S_AINC: begin
        cnt_we      = 1'b1;
        res_valid_d = 1'b1;  res_rec_d = 1'b1;  res_arc_d = 12'(acur_q);
        res_cnt_d   = cnt_rdata_q + 32'd1;  res_status_d = status_q;
        state_d     = S_IDLE;
      end
      S_ANEW: begin
        aused_d = au_inc;
        if ((32'(au_inc) < 32'(arc_limit_i)) && (32'(au_inc) < 32'(ARC_DEPTH))) begin
          ac_we    = 1'b1;  ac_waddr = au_inc[AIW-1:0];
          tm_we    = 1'b1;  tm_waddr = au_inc[AIW-1:0];  tm_wdata = '0;
          an_we    = 1'b1;  an_waddr = au_inc[AIW-1:0];  an_wdata = ahead_q;
          ch_we    = 1'b1;  ch_wdata = au_inc[AIW-1:0];
          cnt_we   = 1'b1;  cnt_waddr = au_inc[AIW-1:0];  cnt_wdata = 32'd1;
          res_valid_d = 1'b1;  res_rec_d = 1'b1;  res_arc_d = 12'(au_inc[AIW-1:0]);
          res_cnt_d = 32'd1;  res_status_d = status_q;
        end else begin
          status_d = ST_AFULL;
          res_valid_d = 1'b1;  res_rec_d = 1'b0;  res_arc_d = '0;
          res_cnt_d = '0;  res_status_d = ST_AFULL;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cused_q     <= '0;
      aused_q     <= '0;
      status_q    <= ST_RUN;
      evcnt_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cused_q     <= cused_d;
      aused_q     <= aused_d;
      status_q    <= status_d;
      evcnt_q     <= evcnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    c_q          <= c_d;
    prev_q       <= prev_d;
    chead_q      <= chead_d;
    ahead_q      <= ahead_d;
    acur_q       <= acur_d;
    aprev_q      <= aprev_d;
    res_rec_q    <= res_rec_d;
    res_arc_q    <= res_arc_d;
    res_cnt_q    <= res_cnt_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (hh_we) hh_mem[hh_waddr] <= hh_wdata;
    hh_rdata_q <= hh_mem[hh_raddr];
    if (ca_we) ca_mem[ca_waddr] <= item_q.caller_pc;
    ca_rdata_q <= ca_mem[c_raddr];
    if (cn_we) cn_mem[cn_waddr] <= cn_wdata;
    cn_rdata_q <= cn_mem[c_raddr];
    if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
    ch_rdata_q <= ch_mem[c_raddr];
    if (ac_we) ac_mem[ac_waddr] <= item_q.callee_pc;
    ac_rdata_q <= ac_mem[a_raddr];
    if (an_we) an_mem[an_waddr] <= an_wdata;
    an_rdata_q <= an_mem[a_raddr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[cnt_raddr];
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    tm_rdata_q <= tm_mem[tm_raddr];
  end

  assign busy_o          = state_q != S_IDLE;
  assign status_o        = status_q;
  assign result_strobe_o = res_valid_q;
  assign recorded_o      = res_rec_q;
  assign arc_index_o     = res_arc_q;
  assign arc_count_o     = res_cnt_q;
  assign table_status_o  = res_status_q;
  assign event_total_o   = evcnt_q;

`include "call_arc_profiler_table_assert.svh"

  `CAP_ASSERT(a_rec_running, res_valid_q && res_rec_q |-> res_status_q == ST_RUN, "recorded with full status")
  `CAP_ASSERT(a_norec_zero, res_valid_q && !res_rec_q |-> res_cnt_q == '0 && res_arc_q == '0, "dropped transaction carries data")
  `CAP_ASSERT(a_clear_quiet, state_q == S_CLEAR |-> !res_valid_q && !pop_o, "activity during clearing pass")
  `CAP_ASSERT_NEXT(a_status_sticky, status_q != ST_RUN, $stable(status_q), "full status changed")

endmodule
